// ===== rtl/c2p_pkg.sv =====
// Shared types, constants and arctangent table for the cartesian to polar converter.
package c2p_pkg;

  // Arctangent table length and number of square root digit steps
  localparam int TABLE_LEN  = 24;
  localparam int SQRT_STEPS = 16;

  // CORDIC datapath widths: x/y carry |v| << 16 plus gain headroom, z is signed
  localparam int CW = 35;
  localparam int ZW = 33;

  // Binary angle constants, 2^32 is a full turn
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF   = 32'h0000_8000;

  typedef logic [31:0] atan_table_t [TABLE_LEN];

  // atan(2^-i) in 32-bit binary angle units, rounded to nearest
  localparam atan_table_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Payload carried down the rotation / square root pipeline
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic [31:0]          rem;
    logic [31:0]          root;
    logic                 x_neg;
    logic                 x_zero;
    logic                 y_neg;
    logic                 y_zero;
  } c2p_data_t;

endpackage

// ===== rtl/c2p_front.sv =====
// Input stages: capture, absolute values and squares, CORDIC and root seeds.
module c2p_front
  import c2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  output logic               out_valid,
  output c2p_data_t          out_data
);

  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic               v0;

  logic signed [31:0] xsq_full;
  logic signed [31:0] ysq_full;
  logic [15:0]        ax_next;
  logic [15:0]        ay_next;

  logic [31:0] xsq;
  logic [31:0] ysq;
  logic [15:0] ax;
  logic [15:0] ay;
  logic        x_neg;
  logic        x_zero;
  logic        y_neg;
  logic        y_zero;
  logic        v1;

  c2p_data_t seed;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= in_valid;
      v1        <= v0;
      out_valid <= v1;
    end
  end

  // stage 0: capture the word
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_coord;
      y_r <= y_coord;
    end
  end

  // stage 1: squares and magnitudes of each axis
  assign xsq_full = x_r * x_r;
  assign ysq_full = y_r * y_r;
  assign ax_next  = x_r[15] ? (16'd0 - $unsigned(x_r)) : $unsigned(x_r);
  assign ay_next  = y_r[15] ? (16'd0 - $unsigned(y_r)) : $unsigned(y_r);

  always_ff @(posedge clk) begin
    if (en) begin
      xsq    <= $unsigned(xsq_full);
      ysq    <= $unsigned(ysq_full);
      ax     <= ax_next;
      ay     <= ay_next;
      x_neg  <= x_r[15];
      x_zero <= (x_r == 16'sd0);
      y_neg  <= y_r[15];
      y_zero <= (y_r == 16'sd0);
    end
  end

  // stage 2: sum of squares feeds the root, |x|,|y| << 16 feed the rotator
  always_comb begin
    seed.cx     = $signed({3'b000, ax, 16'h0000});
    seed.cy     = $signed({3'b000, ay, 16'h0000});
    seed.z      = '0;
    seed.rem    = xsq + ysq;
    seed.root   = '0;
    seed.x_neg  = x_neg;
    seed.x_zero = x_zero;
    seed.y_neg  = y_neg;
    seed.y_zero = y_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= seed;
    end
  end

endmodule

// ===== rtl/c2p_stage.sv =====
// One pipeline step: a CORDIC vectoring rotation and one square root digit, each only where IDX is in its range.
module c2p_stage
  import c2p_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  c2p_data_t in_data,
  output logic      out_valid,
  output c2p_data_t out_data
);

  localparam bit          DO_CORDIC = (IDX < ITERATIONS) && (IDX < TABLE_LEN);
  localparam bit          DO_SQRT   = (IDX < SQRT_STEPS);
  localparam int          TI        = (IDX < TABLE_LEN) ? IDX : 0;
  localparam int          SQ_SH     = DO_SQRT ? (30 - 2 * IDX) : 0;
  localparam logic [31:0] SQ_BIT    = 32'd1 << SQ_SH;

  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [ZW-1:0] step_angle;
  logic [31:0]          trial;
  c2p_data_t            d_next;

  assign sx         = in_data.cx >>> IDX;
  assign sy         = in_data.cy >>> IDX;
  assign step_angle = $signed({1'b0, ATAN_TURNS[TI]});
  assign trial      = in_data.root + SQ_BIT;

  always_comb begin
    d_next = in_data;
    // rotate toward the x axis, direction set by the sign of y
    if (DO_CORDIC) begin
      if (in_data.cy > 0) begin
        d_next.cx = in_data.cx + sy;
        d_next.cy = in_data.cy - sx;
        d_next.z  = in_data.z + step_angle;
      end else begin
        d_next.cx = in_data.cx - sy;
        d_next.cy = in_data.cy + sx;
        d_next.z  = in_data.z - step_angle;
      end
    end
    // restoring square root, two remainder bits per step
    if (DO_SQRT) begin
      if (in_data.rem >= trial) begin
        d_next.rem  = in_data.rem - trial;
        d_next.root = (in_data.root >> 1) + SQ_BIT;
      end else begin
        d_next.root = in_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d_next;
    end
  end

endmodule

// ===== rtl/c2p_back.sv =====
// Output stage: angle clamp, quadrant fold, rounding and the output register.
module c2p_back
  import c2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  c2p_data_t   in_data,
  output logic        out_valid,
  output logic [15:0] magnitude,
  output logic [15:0] angle
);

  logic [31:0] theta;
  logic [31:0] phi;
  logic [31:0] phi_rnd;
  logic [31:0] mag_sum;
  logic        x_ge;
  logic        x_le;
  logic        y_ge;
  logic        y_le;

  // first-quadrant angle; axis cases bypass the rotator
  always_comb begin
    if (in_data.x_zero) begin
      theta = QUARTER_TURN;
    end else if (in_data.y_zero) begin
      theta = '0;
    end else if (in_data.z < 0) begin
      theta = '0;
    end else if (in_data.z > $signed({1'b0, QUARTER_TURN})) begin
      theta = QUARTER_TURN;
    end else begin
      theta = in_data.z[31:0];
    end
  end

  // quadrant fold; on shared boundaries the fourth quadrant rule wins, then third
  assign x_ge = ~in_data.x_neg;
  assign x_le = in_data.x_neg | in_data.x_zero;
  assign y_ge = ~in_data.y_neg;
  assign y_le = in_data.y_neg | in_data.y_zero;

  always_comb begin
    if (x_ge && y_le) begin
      phi = 32'd0 - theta;
    end else if (x_le && y_le) begin
      phi = HALF_TURN + theta;
    end else if (x_le && y_ge) begin
      phi = HALF_TURN - theta;
    end else begin
      phi = theta;
    end
  end

  assign phi_rnd = phi + ROUND_HALF;
  // round the root up when the remainder exceeds it
  assign mag_sum = in_data.root + ((in_data.rem > in_data.root) ? 32'd1 : 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      magnitude <= mag_sum[15:0];
      angle     <= phi_rnd[31:16];
    end
  end

endmodule

// ===== rtl/cartesian_to_polar.sv =====
// Cartesian to polar converter: top level with the pipeline chain and stall control.
//
// Slave stream carries one vector per word, x in the low half and y in the
// high half, both signed. Master stream returns the rounded Euclidean length
// and the direction as a 16-bit binary angle (65536 is a full turn).
// No configuration; items are fully independent.
//
// Pipeline: three front stages (capture, squares, seeds), one stage per
// CORDIC rotation and square root digit, and one output stage.
// Throughput: one word per clock while the receiver takes words; the whole
// pipeline advances as one, so the rate is set by the single enable shared
// by all stage registers.
// Stall: when m_tvalid is high and m_tready low, every stage holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Reset: rst clears all valid bits; s_tready is high right after.
module cartesian_to_polar
  import c2p_pkg::*;
#(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] x_coord, [31:16] y_coord
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [15:0] magnitude, [31:16] angle
);

  localparam int N = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

  logic        en;
  logic        stage_valid [N+1];
  c2p_data_t   stage_data  [N+1];
  logic [15:0] magnitude;
  logic [15:0] angle;

  // shared advance: output register empty or being drained
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  c2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .x_coord   ($signed(s_tdata[15:0])),
    .y_coord   ($signed(s_tdata[31:16])),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  // rotation and root digit chain
  for (genvar k = 0; k < N; k++) begin : g_stage
    c2p_stage #(
      .IDX        (k),
      .ITERATIONS (ITERATIONS)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[k]),
      .in_data   (stage_data[k]),
      .out_valid (stage_valid[k+1]),
      .out_data  (stage_data[k+1])
    );
  end

  c2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stage_valid[N]),
    .in_data   (stage_data[N]),
    .out_valid (m_tvalid),
    .magnitude (magnitude),
    .angle     (angle)
  );

  assign m_tdata = {angle, magnitude};

endmodule

// ===== rtl/c2p_checker.sv =====
// Port-level checker for the cartesian to polar converter, bound to the top level.
module c2p_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result word changed while stalled");

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // input side stalls exactly when the output word is held
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  // length never exceeds the diagonal of the input range
  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] <= 16'd46341))
    else $error("magnitude out of range");

endmodule

bind cartesian_to_polar c2p_checker u_checker (.*);

// ===== test/cartesian_to_polar_tb.sv =====
// Self-checking testbench for the cartesian to polar converter.

// Scoreboard: predicts magnitude and angle of each accepted vector, checks results in order
class polar_scoreboard;
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        magnitude;
    logic [15:0]        angle;
  } polar_word_t;

  polar_word_t pending[$];
  int          rotations;
  int          errors;
  int          checked;
  int          accepted;

  function new(int n);
    rotations = n;
    errors    = 0;
    checked   = 0;
    accepted  = 0;
  endfunction

  // First-quadrant vectoring rotation on (|x|, |y|), result clamped to [0, pi/2]
  function logic [31:0] first_quadrant_angle(longint ax, longint ay);
    longint cx, cy, z, sx, sy;
    cx = ax << 16;
    cy = ay << 16;
    z  = 0;
    for (int i = 0; i < rotations && i < c2p_pkg::TABLE_LEN; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy > 0) begin
        cx = cx + sy;
        cy = cy - sx;
        z  = z + longint'(c2p_pkg::ATAN_TURNS[i]);
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        z  = z - longint'(c2p_pkg::ATAN_TURNS[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(c2p_pkg::QUARTER_TURN)) z = longint'(c2p_pkg::QUARTER_TURN);
    return z[31:0];
  endfunction

  // Square root rounded to nearest, ties upward
  function longint rounded_root(longint n);
    longint r;
    r = longint'($floor($sqrt(real'(n))));
    while (r * r > n) r--;
    while ((r + 1) * (r + 1) <= n) r++;
    if (n - r * r > r) r++;
    return r;
  endfunction

  function void note_input(logic signed [15:0] x, logic signed [15:0] y);
    polar_word_t w;
    longint      ax, ay, root;
    logic [31:0] theta, phi, turn;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    if (x == 0) theta = c2p_pkg::QUARTER_TURN;
    else if (y == 0) theta = '0;
    else theta = first_quadrant_angle(ax, ay);
    // quadrant fix-up, later rules override earlier ones
    phi = '0;
    if (x >= 0 && y >= 0) phi = theta;
    if (x <= 0 && y >= 0) phi = c2p_pkg::HALF_TURN - theta;
    if (x <= 0 && y <= 0) phi = c2p_pkg::HALF_TURN + theta;
    if (x >= 0 && y <= 0) phi = 32'd0 - theta;
    turn = phi + c2p_pkg::ROUND_HALF;
    root = rounded_root(ax * ax + ay * ay);
    w.x = x;
    w.y = y;
    w.magnitude = root[15:0];
    w.angle = turn[31:16];
    pending.push_back(w);
    accepted++;
  endfunction

  function void check_result(logic [15:0] magnitude, logic [15:0] angle);
    polar_word_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word magnitude=%0d angle=%0d", $time, magnitude, angle);
      errors++;
      return;
    end
    w = pending.pop_front();
    checked++;
    if (magnitude !== w.magnitude) begin
      $display("%0t: x=%0d y=%0d magnitude expected %0d actual %0d",
               $time, w.x, w.y, w.magnitude, magnitude);
      errors++;
    end
    if (angle !== w.angle) begin
      $display("%0t: x=%0d y=%0d angle expected %0d actual %0d",
               $time, w.x, w.y, w.angle, angle);
      errors++;
    end
  endfunction
endclass

module cartesian_to_polar_tb;
  import c2p_pkg::*;

  localparam int ROTATIONS    = 16;
  localparam int RANDOM_ITEMS = 1230;
  localparam int QUIET_TAIL   = 200;
  localparam int LONG_HOLD    = 64;
  localparam int DRAIN        = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  bit  quiet = 1'b0;
  bit  long_hold_pending = 1'b0;
  int  cycles = 0;
  int  directed_count = 0;

  polar_scoreboard sb = new(ROTATIONS);

  cartesian_to_polar #(.ITERATIONS(ROTATIONS)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("[cartesian_to_polar] ERROR");
      $finish;
    end
  end

  // output word check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[15:0], m_tdata[31:16]);
  end

  // receiver: random short stalls, one long hold on request, none in the quiet tail
  initial begin : receiver
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one vector, wait for the handshake, maybe leave a gap
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
    s_tdata  <= {y, x};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(x, y);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_directed(logic signed [15:0] x, logic signed [15:0] y);
    send_vector(x, y);
    directed_count++;
  endtask

  initial begin : stimulus
    logic signed [15:0] x, y;
    int                 pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector, axes, corners, unit vectors
    send_directed(16'sd0, 16'sd0);
    send_directed(16'sd32767, 16'sd0);
    send_directed(-16'sd32768, 16'sd0);
    send_directed(16'sd0, 16'sd32767);
    send_directed(16'sd0, -16'sd32768);
    send_directed(16'sd32767, 16'sd32767);
    send_directed(-16'sd32768, -16'sd32768);
    send_directed(16'sd32767, -16'sd32768);
    send_directed(-16'sd32768, 16'sd32767);
    send_directed(16'sd1, 16'sd0);
    send_directed(-16'sd1, 16'sd0);
    send_directed(16'sd0, 16'sd1);
    send_directed(16'sd0, -16'sd1);
    send_directed(16'sd1, 16'sd1);
    send_directed(-16'sd1, -16'sd1);
    send_directed(16'sd1, -16'sd1);
    send_directed(-16'sd1, 16'sd1);
    send_directed(16'sd3, 16'sd4);
    send_directed(-16'sd32768, 16'sd1);
    send_directed(16'sd1, -16'sd32768);
    send_directed(16'sd32767, 16'sd1);
    send_directed(16'sd100, -16'sd200);

    // receiver holds off early in the random part so the pipe backs up
    long_hold_pending = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      pick = $urandom_range(0, 19);
      x = 16'($urandom);
      y = 16'($urandom);
      if (pick >= 12 && pick < 15) begin
        // tiny vectors, rounding dominates
        x = 16'($urandom_range(0, 16)) - 16'd8;
        y = 16'($urandom_range(0, 16)) - 16'd8;
      end else if (pick >= 15 && pick < 17) begin
        // on an axis
        if ($urandom_range(0, 1) == 0) x = '0;
        else y = '0;
      end else if (pick >= 17) begin
        // near a diagonal
        y = ($urandom_range(0, 1) == 0) ? x : -x;
        y = y + 16'($urandom_range(0, 6)) - 16'd3;
      end
      send_vector(x, y);
    end
    s_tvalid <= 1'b0;
    quiet = 1'b1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d vectors (%0d directed: zero, axes, corners, units), %0d words checked,",
             sb.accepted, directed_count, sb.checked);
    $display("with random stalls on both streams and one %0d-cycle output hold.", LONG_HOLD);
    if (sb.errors == 0) begin
      $display("[cartesian_to_polar] OK");
    end else begin
      $display("[cartesian_to_polar] ERROR");
    end
    $finish;
  end
endmodule
